FILE: rtl/core/per_topic_snowflake_id_generator_defines.svh
// Assertion macros shared by the checkers of the snowflake id generator.
// No dependencies; the include guard keeps repeated inclusion harmless.
`ifndef PER_TOPIC_SNOWFLAKE_ID_GENERATOR_DEFINES_SVH
`define PER_TOPIC_SNOWFLAKE_ID_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSFID_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snowflake id generator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSFID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snowflake id generator: next-cycle check failed");

`endif

FILE: rtl/core/psfid_pkg.sv
// Package of the per-topic snowflake id generator: widths, types and constants.
// Used by the table, the id unit and the top level.
package psfid_pkg;

  localparam int unsigned Topics     = 32;
  localparam int unsigned TopicAw    = $clog2(Topics);
  localparam int unsigned TopicW     = 5;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned TimeW      = 48;
  localparam int unsigned SeqW       = 12;
  localparam int unsigned MachW      = 5;
  localparam int unsigned CountW     = 6;
  localparam int unsigned IdW        = 64;
  localparam int unsigned TimeShift  = 22;
  localparam int unsigned DeltaW     = IdW - TimeShift;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned InDataW    = 56;
  localparam int unsigned OutUserW   = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMachineId  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEpochMs    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTopicCount = 2'd2;

  localparam logic [SeqW-1:0] SeqMax = {SeqW{1'b1}};

  // One row of the topic table.
  typedef struct packed {
    logic [TimeW-1:0] last_time;
    logic [SeqW-1:0]  seq;
  } entry_t;

  // A request after topic resolution.
  typedef struct packed {
    logic [TopicAw-1:0] topic;
    logic [TimeW-1:0]   now_ms;
    logic               used_default;
  } req_t;

  // One finished result.
  typedef struct packed {
    logic [IdW-1:0] unique_id;
    logic           sequence_wrapped;
    logic           used_default;
  } result_t;

endpackage

FILE: rtl/core/psfid_table.sv
// Topic table: one synchronous memory of last time and sequence per topic.
// Depends on psfid_pkg; valid bits make never-written rows read as zero.
module psfid_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [psfid_pkg::TopicAw-1:0] rd_addr_i,
  output psfid_pkg::entry_t        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [psfid_pkg::TopicAw-1:0] wr_addr_i,
  input  psfid_pkg::entry_t        wr_data_i
);
  import psfid_pkg::*;

  entry_t            mem [Topics];
  entry_t            rd_raw_q;
  logic              rd_valid_q;
  logic [Topics-1:0] valid_q;

  // Memory array: registered read, single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
  end

  // Valid bits stand in for the all-zero reset of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

FILE: rtl/core/psfid_id_unit.sv
// Id unit: sequence update and id packing from one table row and one request.
// Depends on psfid_pkg.
module psfid_id_unit (
  input  psfid_pkg::req_t                    req_i,
  input  psfid_pkg::entry_t                  entry_i,
  input  logic [psfid_pkg::MachW-1:0]        machine_id_i,
  input  logic [psfid_pkg::TimeW-1:0]        epoch_ms_i,
  output psfid_pkg::entry_t                  entry_o,
  output psfid_pkg::result_t                 result_o
);
  import psfid_pkg::*;

  logic             same_ms;
  logic [SeqW-1:0]  seq_next;
  logic [TimeW-1:0] delta;

  // Same millisecond advances the sequence, any other time restarts it.
  assign same_ms  = (entry_i.last_time == req_i.now_ms);
  assign seq_next = same_ms ? (entry_i.seq + SeqW'(1)) : '0;
  assign delta    = req_i.now_ms - epoch_ms_i;

  assign entry_o.last_time = req_i.now_ms;
  assign entry_o.seq       = seq_next;

  // Pack time delta, machine, topic and sequence.
  assign result_o.unique_id = {delta[DeltaW-1:0], machine_id_i,
                               TopicW'(req_i.topic), seq_next};
  assign result_o.sequence_wrapped = same_ms && (entry_i.seq == SeqMax);
  assign result_o.used_default     = req_i.used_default;

endmodule

FILE: rtl/core/per_topic_snowflake_id_generator.sv
// Per-topic snowflake id generator, top level.
// A request is registered with its table read on acceptance, and its result and the table
// write-back follow once the output register is free; only then is a new request accepted.
// Reset: asynchronous, active low; clears the config and control registers and the table
// valid bits at once: every topic reads as time zero and sequence zero, no clearing pass.
module per_topic_snowflake_id_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [psfid_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [psfid_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: topic_index[5:0], now_ms[53:6], zero pad[55:54].
  input  logic [psfid_pkg::InDataW-1:0]     s_axis_tdata,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: unique_id[63:0].
  output logic [psfid_pkg::IdW-1:0]         m_axis_tdata,
  // Fields from bit 0: sequence_wrapped[0], used_default[1].
  output logic [psfid_pkg::OutUserW-1:0]    m_axis_tuser
);
  import psfid_pkg::*;

  localparam logic [CountW-1:0] TopicsCount = CountW'(Topics);

  logic [MachW-1:0]  machine_id_q;
  logic [TimeW-1:0]  epoch_ms_q;
  logic [CountW-1:0] topic_count_q;

  logic [IdxW-1:0]   in_idx;
  logic [TimeW-1:0]  in_now;
  logic [CountW-1:0] limit;
  logic              in_fallback;
  logic              s_accept;
  logic              load_out;

  req_t    req_d, req_q;
  logic    busy_q, busy_d;
  entry_t  rd_entry, wr_entry;
  result_t result, out_q;
  logic    out_valid_q, out_valid_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machine_id_q  <= '0;
      epoch_ms_q    <= '0;
      topic_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMachineId:  machine_id_q  <= cfg_wdata_i[MachW-1:0];
        RegEpochMs:    epoch_ms_q    <= cfg_wdata_i[TimeW-1:0];
        RegTopicCount: topic_count_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Topic resolution: unknown indices fall back to topic zero.
  assign in_idx      = s_axis_tdata[IdxW-1:0];
  assign in_now      = s_axis_tdata[IdxW+TimeW-1:IdxW];
  assign limit       = (topic_count_q > TopicsCount) ? TopicsCount : topic_count_q;
  assign in_fallback = (in_idx >= IdxW'(limit));

  always_comb begin
    req_d.now_ms       = in_now;
    req_d.used_default = in_fallback;
    req_d.topic        = in_fallback ? '0 : in_idx[TopicAw-1:0];
  end

  // One request in flight: accept, read the row, then write it back.
  assign s_axis_tready = !busy_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign load_out      = busy_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    busy_d = busy_q;
    if (s_accept) begin
      busy_d = 1'b1;
    end else if (load_out) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q <= req_d;
    end
  end

  psfid_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_accept),
    .rd_addr_i (req_d.topic),
    .rd_data_o (rd_entry),
    .wr_en_i   (load_out),
    .wr_addr_i (req_q.topic),
    .wr_data_i (wr_entry)
  );

  psfid_id_unit u_id_unit (
    .req_i        (req_q),
    .entry_i      (rd_entry),
    .machine_id_i (machine_id_q),
    .epoch_ms_i   (epoch_ms_q),
    .entry_o      (wr_entry),
    .result_o     (result)
  );

  // Output register parts the result stream from the table access.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.unique_id;
  assign m_axis_tuser  = {out_q.used_default, out_q.sequence_wrapped};

endmodule

FILE: rtl/core/psfid_checker.sv
// Port-level checker for the per-topic snowflake id generator, with its bind.
// Depends on psfid_pkg and the assertion macros header.
`include "per_topic_snowflake_id_generator_defines.svh"

module psfid_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [psfid_pkg::IdW-1:0]      m_axis_tdata,
  input logic [psfid_pkg::OutUserW-1:0] m_axis_tuser
);
  import psfid_pkg::*;

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // A stalled result stays offered.
  `PSFID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // An accepted request blocks the next one while the table row is in flight.
  `PSFID_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_accept, !s_axis_tready)

  // A request whose result can move on is loaded into the output register once its table row is read.
  `PSFID_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, $past(s_accept) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

  // A fallback request always carries topic zero in its id.
  `PSFID_ASSERT_IMPL(a_default_topic, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[16:12] == 5'd0)

endmodule

bind per_topic_snowflake_id_generator psfid_checker u_psfid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
